>>> hdl/dvb_pkg.sv
// Shared types and constants for the delta variable-byte encoder.
// No dependencies; imported by dvb_emit and delta_varbyte_encoder.
package dvb_pkg;

    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned MAX_GROUPS = 5;
    localparam logic        CONT_FLAG  = 1'b1;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [2:0]            t_idx;
    typedef logic [GROUP_BITS-1:0] t_group;

    typedef struct packed {
        logic   valid;
        t_value code;
        t_idx   top;
    } t_item;

    // Index of the most significant group that is emitted: floor(bitlength / 7).
    function automatic t_idx top_group(input t_value code);
        t_idx idx;
        idx = 3'd0;
        if (code[VALUE_BITS-1:6]  != '0) idx = 3'd1;
        if (code[VALUE_BITS-1:13] != '0) idx = 3'd2;
        if (code[VALUE_BITS-1:20] != '0) idx = 3'd3;
        if (code[VALUE_BITS-1:27] != '0) idx = 3'd4;
        return idx;
    endfunction

endpackage

>>> hdl/dvb_emit.sv
// Byte emitter: holds one coded value and walks its 7-bit groups, top first.
// Depends on dvb_pkg for the item struct and group constants.
module dvb_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dvb_pkg::t_item i_item,
    output logic          o_take,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_last_byte
);
    import dvb_pkg::*;

    logic   r_valid, n_valid;
    t_value r_code,  n_code;
    t_idx   r_idx,   n_idx;
    logic   w_fire;
    t_group w_group;

    assign w_fire = r_valid && !i_stall;
    assign o_take = !r_valid || (w_fire && r_idx == 3'd0);

    always_comb begin
        n_valid = r_valid;
        n_code  = r_code;
        n_idx   = r_idx;
        if (o_take) begin
            n_valid = i_item.valid;
            n_code  = i_item.code;
            n_idx   = i_item.top;
        end else if (w_fire) begin
            n_idx = r_idx - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_code <= n_code;
        r_idx  <= n_idx;
    end

    always_comb begin
        case (r_idx)
            3'd0:    w_group = r_code[6:0];
            3'd1:    w_group = r_code[13:7];
            3'd2:    w_group = r_code[20:14];
            3'd3:    w_group = r_code[27:21];
            3'd4:    w_group = {3'b000, r_code[31:28]};
            default: w_group = '0;
        endcase
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = {w_group, (r_idx != 3'd0) ? CONT_FLAG : ~CONT_FLAG};
    assign o_last_byte = (r_idx == 3'd0);

endmodule

>>> hdl/delta_varbyte_encoder.sv
// Delta variable-byte encoder, top level: input register, delta and group count.
// Depends on dvb_pkg and dvb_emit.
//
// Each request carries a 32-bit value and a flag that starts a new list. The
// first value of a list is coded as is; later values are coded as the
// difference from the previous value, modulo 2^32. A code of bit length L goes
// out as floor(L/7)+1 bytes, top 7-bit group first, the group in bits 7..1
// and a continuation flag in bit 0 on all but the final byte, which also
// raises o_last_byte. One byte leaves per cycle while i_stall is low, so a
// value goes out as 1 to 5 bytes on the one-byte result channel; the next
// request is taken into the input register while the current one is emitted,
// so there is no gap between values. Each value is held in r_a, then in u_emit.
module delta_varbyte_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    input  logic        i_first,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);
    import dvb_pkg::*;

    t_value r_prev, n_prev;
    t_item  r_a,    n_a;
    t_value w_code;
    logic   w_take;
    logic   w_accept;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = r_a.valid && !w_take;
    assign w_code   = i_first ? i_value : i_value - r_prev;

    always_comb begin
        n_prev = r_prev;
        n_a    = r_a;
        if (w_take) begin
            n_a.valid = 1'b0;
        end
        if (w_accept) begin
            n_prev    = i_value;
            n_a.valid = 1'b1;
            n_a.code  = w_code;
            n_a.top   = top_group(w_code);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_a.valid <= 1'b0;
        end else begin
            r_prev    <= n_prev;
            r_a.valid <= n_a.valid;
        end
        r_a.code <= n_a.code;
        r_a.top  <= n_a.top;
    end

    dvb_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (r_a),
        .o_take      (w_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    a_cont_matches_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_byte[0] != o_last_byte))
        else $error("continuation flag disagrees with last byte");

    a_code_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_byte) |=> o_valid)
        else $error("byte sequence broken before last byte");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a.valid && o_valid))
        else $error("input stalled while a stage is free");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for delta_varbyte_encoder: directed and random lists,
// bursty requests and an output side that stalls, including one long hold-off.
// Depends on dvb_pkg and the delta_varbyte_encoder RTL.
module tb_top;
    import dvb_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 150;
    localparam int LONG_HOLD    = 80;
    localparam int HOLD_AFTER   = 40;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
    } t_coded_byte;

    class byte_scoreboard;
        t_value      prev_value;
        t_coded_byte pending[$];
        int          errors;
        int          values_noted;
        int          bytes_checked;

        function new();
            prev_value    = '0;
            errors        = 0;
            values_noted  = 0;
            bytes_checked = 0;
        endfunction

        function void note_value(t_value value, logic first);
            t_value      code;
            int          len;
            int          top;
            t_group      group;
            t_coded_byte cb;
            code = first ? value : t_value'(value - prev_value);
            prev_value = value;
            len = 0;
            for (int i = 0; i < VALUE_BITS; i++) begin
                if (code[i]) len = i + 1;
            end
            top = len / GROUP_BITS;
            for (int j = top; j >= 0; j--) begin
                group = t_group'(code >> (GROUP_BITS * j));
                cb.code_byte = {group, (j > 0) ? CONT_FLAG : ~CONT_FLAG};
                cb.last = (j == 0);
                pending = {pending, cb};
            end
            values_noted++;
        endfunction

        function void check_byte(logic [7:0] code_byte, logic last);
            t_coded_byte want;
            if (pending.size() == 0) begin
                $error("unexpected byte: out_byte=%02h last_byte=%0b", code_byte, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            bytes_checked++;
            if (code_byte !== want.code_byte) begin
                $error("out_byte mismatch: expected %02h actual %02h",
                       want.code_byte, code_byte);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_byte mismatch: expected %0b actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_value = '0;
    logic        i_first = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    byte_scoreboard sb = new();
    int     cycles = 0;
    int     burst_left = 0;
    bit     held_long = 1'b0;
    t_value list_prev = '0;

    delta_varbyte_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_first     (i_first),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_value(i_value, i_first);
            if (o_valid && !i_stall) sb.check_byte(o_out_byte, o_last_byte);
        end
    end

    // Output side: free runs, random stalls, periodic stalls, one long hold-off.
    initial begin
        int mode;
        int seg;
        int period;
        wait (i_rst_n);
        forever begin
            if (!held_long && sb.values_noted >= HOLD_AFTER) begin
                held_long = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
            mode   = $urandom_range(0, 2);
            seg    = $urandom_range(5, 40);
            period = $urandom_range(2, 5);
            for (int k = 0; k < seg; k++) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 1) == 1);
                    default: i_stall <= (k % period == 0);
                endcase
            end
        end
    end

    task automatic send_item(input t_value value, input logic first);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= value;
        i_first <= first;
        do @(posedge i_clk); while (o_stall);
        list_prev = value;
    endtask

    function automatic t_value rand_delta();
        int     len;
        t_value d;
        len = $urandom_range(0, VALUE_BITS);
        if (len == 0) return '0;
        d = t_value'($urandom) >> (VALUE_BITS - len);
        d[len-1] = 1'b1;
        return d;
    endfunction

    initial begin
        int kind;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no start flag right after reset: delta from zero
        send_item(32'h0001_2345, 1'b0);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h0000_003F, 1'b1);
        send_item(32'h0000_0040, 1'b1);
        send_item(32'h0000_007F, 1'b1);
        send_item(32'h0000_0080, 1'b1);
        send_item(32'h0000_1FFF, 1'b1);
        send_item(32'h0000_3FFF, 1'b1);
        send_item(32'h000F_FFFF, 1'b1);
        send_item(32'h0FFF_FFFF, 1'b1);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'h5555_5555, 1'b1);
        send_item(32'hAAAA_AAAA, 1'b1);
        send_item(32'h0000_0064, 1'b1);
        send_item(32'h0000_0032, 1'b0);
        send_item(32'h0000_0001, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'h0000_007F, 1'b0);
        send_item(32'h0000_3FFF, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; ) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                send_item(t_value'($urandom) >> $urandom_range(0, 31), 1'b1);
                n++;
                for (int m = $urandom_range(1, 10); m > 0 && n < RANDOM_ITEMS; m--) begin
                    send_item(t_value'(list_prev + rand_delta()), 1'b0);
                    n++;
                end
            end else begin
                send_item(t_value'($urandom), $urandom_range(0, 1));
                n++;
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d values (directed edges, sorted lists, wrapping deltas)",
                 sb.values_noted);
        $display("checked %0d bytes under bursty input and output stalls", sb.bytes_checked);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
